### rtl/core/buddy_allocator_lazy_coalesce_core_assert.svh
// ----------------------------------------------------------------------------
// Buddy allocator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUDDY_ALLOCATOR_LAZY_COALESCE_CORE_ASSERT_SVH
`define BUDDY_ALLOCATOR_LAZY_COALESCE_CORE_ASSERT_SVH

// Condition that must hold at every clock edge.
`define BALC_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define BALC_IMPL_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/balc_pkg.sv
// ----------------------------------------------------------------------------
// Buddy allocator package
// Operation and status codes, controller states, commands and status struct.
// ----------------------------------------------------------------------------
package balc_pkg;

  localparam int unsigned MaxBlocksDef  = 256;
  localparam int unsigned MinBlockKbDef = 32;
  localparam int unsigned OwnerBitsDef  = 16;

  localparam logic [13:0] TotalKbRst = 14'd1024;

  localparam logic CfgTotalKb      = 1'b0;
  localparam logic CfgCoalesceMode = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MERGE   = 2'd2,
    OP_REINIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_DONE     = 2'd0,
    STS_NO_FIT   = 2'd1,
    STS_NO_OWNER = 2'd2,
    STS_NO_PAIR  = 2'd3
  } sts_e;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_REINIT, S_SCAN_RD, S_SCAN_EV, S_CALC, S_SHR_RD, S_SHR_WR,
    S_FILL, S_ALLOC_WR, S_REL_WR, S_PAIR_START, S_PAIR_RD, S_PAIR_EV, S_MERGE_WR,
    S_SHL_RD, S_SHL_WR, S_MERGE_END, S_DONE
  } state_e;

  typedef enum logic [4:0] {
    C_NONE, C_INIT, C_ACCEPT, C_REINIT, C_SCAN_RD, C_SCAN_EV, C_CALC, C_SHR_RD,
    C_SHR_WR, C_FILL, C_ALLOC_WR, C_REL_WR, C_PAIR_START, C_PAIR_RD, C_PAIR_EV,
    C_MERGE_WR, C_SHL_RD, C_SHL_WR, C_MERGE_END, C_DONE
  } dp_cmd_e;

  typedef struct packed {
    logic scan_end;
    logic scan_hit;
    logic split_more;
    logic no_split;
    logic tail_some;
    logic shr_last;
    logic fill_last;
    logic pair_hit;
    logic found;
    logic shl_more;
    logic lazy;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/core/balc_dpath.sv
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Block list memory, scan pointers, split and merge bookkeeping, result regs.
// ----------------------------------------------------------------------------
module balc_dpath #(
  parameter int unsigned MaxBlocks  = 256,
  parameter int unsigned MinBlockKb = 32,
  parameter int unsigned OwnerBits  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  balc_pkg::dp_cmd_e  cmd_i,
  output balc_pkg::dp_stat_t stat_o,
  input  logic [1:0]         operation_i,
  input  logic [13:0]        request_kb_i,
  input  logic [15:0]        owner_id_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [13:0]        cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [12:0]        block_offset_kb_o,
  output logic [13:0]        block_size_kb_o,
  output logic               merged_o
);
  import balc_pkg::*;

  localparam int unsigned AW = $clog2(MaxBlocks);
  localparam int unsigned CW = $clog2(MaxBlocks + 1);

  function automatic logic [31:0] size_of(input logic [3:0] ord);
    return 32'(MinBlockKb) << ord;
  endfunction

  function automatic logic [3:0] top_of(input logic [13:0] tot);
    logic [3:0] k;
    k = 4'd0;
    for (int t = 1; t < 16; t++) begin
      if ((32'(MinBlockKb) << t) <= {18'd0, tot}) k = 4'(t);
    end
    return k;
  endfunction

  function automatic logic [12:0] off_of(input logic [15:0] units);
    logic [31:0] p;
    p = {16'd0, units} * 32'(MinBlockKb);
    return p[12:0];
  endfunction

  localparam logic [3:0] TopRst = top_of(TotalKbRst);

  // Block list storage.
  logic [3:0]           mem_ord  [MaxBlocks];
  logic                 mem_free [MaxBlocks];
  logic [OwnerBits-1:0] mem_own  [MaxBlocks];

  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [3:0]           w_ord;
  logic                 w_free;
  logic [OwnerBits-1:0] w_own;

  logic [3:0]           rd_ord_q;
  logic                 rd_free_q;
  logic [OwnerBits-1:0] rd_own_q;

  logic [13:0]          total_q;
  logic                 mode_q;
  logic [3:0]           top_q;
  logic [CW-1:0]        cnt_q;

  logic [1:0]           op_q;
  logic [13:0]          req_q;
  logic [OwnerBits-1:0] own_q;

  logic [CW-1:0]        idx_q, ptr_q, hit_q;
  logic [15:0]          u_q, hit_u_q, prev_u_q;
  logic [3:0]           o_q, s_q, hit_ord_q, prev_ord_q;
  logic                 prev_free_q, found_q;
  logic [4:0]           best_q;

  logic [1:0]           res_sts_q;
  logic [12:0]          res_off_q;
  logic [13:0]          res_size_q;
  logic                 res_mg_q;

  logic                 out_valid_q;
  logic [1:0]           out_sts_q;
  logic [12:0]          out_off_q;
  logic [13:0]          out_size_q;
  logic                 out_mg_q;

  logic                 scan_hit, pair_hit, split_more, scan_end, pair_take;
  logic [3:0]           fill_ord;
  logic [3:0]           top_new;
  logic [CW-1:0]        ptr_tail;

  assign top_new  = top_of(total_q);
  assign scan_end = idx_q >= cnt_q;
  assign fill_ord = o_q + 4'(ptr_q - hit_q - CW'(1));
  assign ptr_tail = (cnt_q - CW'(1) > hit_q) ? cnt_q - CW'(1) : hit_q + CW'(1);

  always_comb begin
    if (op_q == OP_ALLOC) begin
      scan_hit = rd_free_q && (size_of(rd_ord_q) >= {18'd0, req_q});
    end else begin
      scan_hit = !rd_free_q && (rd_own_q == own_q);
    end
  end

  assign split_more = (o_q != 4'd0) && (size_of(o_q - 4'd1) >= {18'd0, req_q}) &&
                      ((32'(cnt_q) + 32'(s_q)) < 32'(MaxBlocks));

  // An aligned buddy pair is two free blocks of one order whose first starts on
  // a multiple of twice their size, below the top order of the store.
  assign pair_hit = (idx_q != '0) && prev_free_q && rd_free_q && (rd_ord_q == prev_ord_q) &&
                    !prev_u_q[prev_ord_q] && (prev_ord_q < top_q);
  assign pair_take = pair_hit && ((op_q == OP_RELEASE) || ({1'b0, prev_ord_q} < best_q));

  always_comb begin
    stat_o.scan_end   = scan_end;
    stat_o.scan_hit   = scan_hit;
    stat_o.split_more = split_more;
    stat_o.no_split   = s_q == 4'd0;
    stat_o.tail_some  = cnt_q - CW'(1) > hit_q;
    stat_o.shr_last   = ptr_q == hit_q + CW'(1);
    stat_o.fill_last  = ptr_q == hit_q + CW'(s_q);
    stat_o.pair_hit   = pair_hit;
    stat_o.found      = found_q;
    stat_o.shl_more   = ptr_q < cnt_q;
    stat_o.lazy       = mode_q;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Memory port selection.
  always_comb begin
    we     = 1'b0;
    re     = 1'b0;
    waddr  = '0;
    raddr  = '0;
    w_ord  = 4'd0;
    w_free = 1'b1;
    w_own  = '0;
    case (cmd_i)
      C_INIT: begin
        we    = 1'b1;
        w_ord = top_q;
      end
      C_REINIT: begin
        we    = 1'b1;
        w_ord = top_new;
      end
      C_SCAN_RD, C_PAIR_RD: begin
        re    = !scan_end;
        raddr = idx_q[AW-1:0];
      end
      C_SHR_RD, C_SHL_RD: begin
        re    = (cmd_i == C_SHR_RD) || (ptr_q < cnt_q);
        raddr = ptr_q[AW-1:0];
      end
      C_SHR_WR: begin
        we     = 1'b1;
        waddr  = ptr_q[AW-1:0] + AW'(s_q);
        w_ord  = rd_ord_q;
        w_free = rd_free_q;
        w_own  = rd_own_q;
      end
      C_SHL_WR: begin
        we     = 1'b1;
        waddr  = ptr_q[AW-1:0] - AW'(1);
        w_ord  = rd_ord_q;
        w_free = rd_free_q;
        w_own  = rd_own_q;
      end
      C_FILL: begin
        we    = 1'b1;
        waddr = ptr_q[AW-1:0];
        w_ord = fill_ord;
      end
      C_ALLOC_WR: begin
        we     = 1'b1;
        waddr  = hit_q[AW-1:0];
        w_ord  = o_q;
        w_free = 1'b0;
        w_own  = own_q;
      end
      C_REL_WR: begin
        we    = 1'b1;
        waddr = hit_q[AW-1:0];
        w_ord = o_q;
      end
      C_MERGE_WR: begin
        we    = 1'b1;
        waddr = hit_q[AW-1:0];
        w_ord = hit_ord_q + 4'd1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_ord[waddr]  <= w_ord;
      mem_free[waddr] <= w_free;
      mem_own[waddr]  <= w_own;
    end
    if (re) begin
      rd_ord_q  <= mem_ord[raddr];
      rd_free_q <= mem_free[raddr];
      rd_own_q  <= mem_own[raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TotalKbRst;
      mode_q      <= 1'b0;
      top_q       <= TopRst;
      cnt_q       <= CW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgTotalKb) begin
          total_q <= cfg_wdata_i;
        end else begin
          mode_q <= cfg_wdata_i[0];
        end
      end
      case (cmd_i)
        C_REINIT: begin
          top_q <= top_new;
          cnt_q <= CW'(1);
        end
        C_ALLOC_WR:  cnt_q <= cnt_q + CW'(s_q);
        C_MERGE_END: cnt_q <= cnt_q - CW'(1);
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
      if (cmd_i == C_DONE && stat_o.out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      C_ACCEPT: begin
        op_q     <= operation_i;
        req_q    <= request_kb_i;
        own_q    <= OwnerBits'(owner_id_i);
        idx_q    <= '0;
        u_q      <= 16'd0;
        found_q  <= 1'b0;
        best_q   <= 5'd16;
        res_mg_q <= 1'b0;
      end
      C_REINIT: begin
        res_sts_q  <= STS_DONE;
        res_off_q  <= 13'd0;
        res_size_q <= 14'(size_of(top_new));
        res_mg_q   <= 1'b0;
      end
      C_SCAN_RD: begin
        if (scan_end) begin
          res_sts_q  <= (op_q == OP_ALLOC) ? STS_NO_FIT : STS_NO_OWNER;
          res_off_q  <= 13'd0;
          res_size_q <= 14'd0;
          res_mg_q   <= 1'b0;
        end
      end
      C_SCAN_EV: begin
        if (scan_hit) begin
          hit_q   <= idx_q;
          hit_u_q <= u_q;
          o_q     <= rd_ord_q;
          s_q     <= 4'd0;
        end else begin
          u_q   <= u_q + (16'd1 << rd_ord_q);
          idx_q <= idx_q + CW'(1);
        end
      end
      C_CALC: begin
        if (split_more) begin
          o_q <= o_q - 4'd1;
          s_q <= s_q + 4'd1;
        end else begin
          ptr_q <= ptr_tail;
        end
      end
      C_SHR_WR: begin
        ptr_q <= stat_o.shr_last ? ptr_q : ptr_q - CW'(1);
      end
      C_FILL: ptr_q <= ptr_q + CW'(1);
      C_ALLOC_WR, C_REL_WR: begin
        res_sts_q  <= STS_DONE;
        res_off_q  <= off_of(hit_u_q);
        res_size_q <= 14'(size_of(o_q));
      end
      C_PAIR_START: begin
        idx_q   <= '0;
        u_q     <= 16'd0;
        found_q <= 1'b0;
        best_q  <= 5'd16;
      end
      C_PAIR_RD: begin
        if (scan_end && !found_q && op_q == OP_MERGE) begin
          res_sts_q  <= STS_NO_PAIR;
          res_off_q  <= 13'd0;
          res_size_q <= 14'd0;
          res_mg_q   <= 1'b0;
        end
      end
      C_PAIR_EV: begin
        if (pair_take) begin
          hit_q     <= idx_q - CW'(1);
          hit_u_q   <= prev_u_q;
          hit_ord_q <= prev_ord_q;
          best_q    <= {1'b0, prev_ord_q};
          found_q   <= 1'b1;
        end
        prev_ord_q  <= rd_ord_q;
        prev_free_q <= rd_free_q;
        prev_u_q    <= u_q;
        u_q         <= u_q + (16'd1 << rd_ord_q);
        idx_q       <= idx_q + CW'(1);
      end
      C_MERGE_WR: begin
        res_mg_q <= 1'b1;
        ptr_q    <= hit_q + CW'(2);
        if (op_q == OP_MERGE) begin
          res_sts_q  <= STS_DONE;
          res_off_q  <= off_of(hit_u_q);
          res_size_q <= 14'(size_of(hit_ord_q + 4'd1));
        end
      end
      C_SHL_WR: ptr_q <= ptr_q + CW'(1);
      C_DONE: begin
        if (stat_o.out_free) begin
          out_sts_q  <= res_sts_q;
          out_off_q  <= res_off_q;
          out_size_q <= res_size_q;
          out_mg_q   <= res_mg_q;
        end
      end
      default: begin
        op_q <= op_q;
      end
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_sts_q;
  assign block_offset_kb_o = out_off_q;
  assign block_size_kb_o   = out_size_q;
  assign merged_o          = out_mg_q;

`include "buddy_allocator_lazy_coalesce_core_assert.svh"

  `BALC_CHECK(a_cnt_range, (cnt_q >= CW'(1)) && (32'(cnt_q) <= 32'(MaxBlocks)), "count out of range")
  `BALC_CHECK(a_alloc_hit, (cmd_i != C_ALLOC_WR) || (hit_q < cnt_q), "grant beyond list end")
  `BALC_IMPL_NEXT(a_merge_shrinks, cmd_i == C_MERGE_END, cnt_q == $past(cnt_q) - CW'(1), "merge count")

endmodule

### rtl/core/balc_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences scans, splits, list shifts, merges and reinitialization for each accepted item.
// ----------------------------------------------------------------------------
module balc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  balc_pkg::dp_stat_t stat_i,
  output balc_pkg::dp_cmd_e  cmd_o
);
  import balc_pkg::*;

  state_e state_q, state_d;
  op_e    op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      op_q    <= OP_ALLOC;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && in_valid_i) op_q <= op_e'(operation_i);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(operation_i))
            OP_ALLOC, OP_RELEASE: state_d = S_SCAN_RD;
            OP_MERGE:             state_d = S_PAIR_START;
            default:              state_d = S_REINIT;
          endcase
        end
      end
      S_REINIT:  state_d = S_DONE;
      S_SCAN_RD: state_d = stat_i.scan_end ? S_DONE : S_SCAN_EV;
      S_SCAN_EV: begin
        if (stat_i.scan_hit) begin
          state_d = (op_q == OP_ALLOC) ? S_CALC : S_REL_WR;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_CALC: begin
        if (stat_i.split_more)     state_d = S_CALC;
        else if (stat_i.no_split)  state_d = S_ALLOC_WR;
        else if (stat_i.tail_some) state_d = S_SHR_RD;
        else                       state_d = S_FILL;
      end
      S_SHR_RD:     state_d = S_SHR_WR;
      S_SHR_WR:     state_d = stat_i.shr_last ? S_FILL : S_SHR_RD;
      S_FILL:       state_d = stat_i.fill_last ? S_ALLOC_WR : S_FILL;
      S_ALLOC_WR:   state_d = S_DONE;
      S_REL_WR:     state_d = stat_i.lazy ? S_DONE : S_PAIR_START;
      S_PAIR_START: state_d = S_PAIR_RD;
      S_PAIR_RD: begin
        if (!stat_i.scan_end)  state_d = S_PAIR_EV;
        else if (stat_i.found) state_d = S_MERGE_WR;
        else                   state_d = S_DONE;
      end
      S_PAIR_EV: begin
        state_d = (stat_i.pair_hit && op_q == OP_RELEASE) ? S_MERGE_WR : S_PAIR_RD;
      end
      S_MERGE_WR:  state_d = S_SHL_RD;
      S_SHL_RD:    state_d = stat_i.shl_more ? S_SHL_WR : S_MERGE_END;
      S_SHL_WR:    state_d = S_SHL_RD;
      S_MERGE_END: state_d = (op_q == OP_RELEASE) ? S_PAIR_START : S_DONE;
      S_DONE:      state_d = stat_i.out_free ? S_IDLE : S_DONE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = state_q != S_IDLE;
    case (state_q)
      S_INIT:       cmd_o = C_INIT;
      S_IDLE:       cmd_o = in_valid_i ? C_ACCEPT : C_NONE;
      S_REINIT:     cmd_o = C_REINIT;
      S_SCAN_RD:    cmd_o = C_SCAN_RD;
      S_SCAN_EV:    cmd_o = C_SCAN_EV;
      S_CALC:       cmd_o = C_CALC;
      S_SHR_RD:     cmd_o = C_SHR_RD;
      S_SHR_WR:     cmd_o = C_SHR_WR;
      S_FILL:       cmd_o = C_FILL;
      S_ALLOC_WR:   cmd_o = C_ALLOC_WR;
      S_REL_WR:     cmd_o = C_REL_WR;
      S_PAIR_START: cmd_o = C_PAIR_START;
      S_PAIR_RD:    cmd_o = C_PAIR_RD;
      S_PAIR_EV:    cmd_o = C_PAIR_EV;
      S_MERGE_WR:   cmd_o = C_MERGE_WR;
      S_SHL_RD:     cmd_o = C_SHL_RD;
      S_SHL_WR:     cmd_o = C_SHL_WR;
      S_MERGE_END:  cmd_o = C_MERGE_END;
      S_DONE:       cmd_o = C_DONE;
      default:      cmd_o = C_NONE;
    endcase
  end

`include "buddy_allocator_lazy_coalesce_core_assert.svh"

  `BALC_IMPL_NEXT(a_accept_leaves_idle, state_q == S_IDLE && in_valid_i, state_q != S_IDLE, "stuck idle")
  `BALC_IMPL_NEXT(a_init_once, state_q != S_INIT, state_q != S_INIT, "init re-entered")

endmodule

### rtl/core/buddy_allocator_lazy_coalesce_core.sv
// ----------------------------------------------------------------------------
// Buddy allocator with lazy coalescing
// Address-ordered power-of-two block list with allocate, release, merge step
// and reinitialize operations.
// ----------------------------------------------------------------------------
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   input    | in_valid_i/in_stall_o | operation, request_kb, owner_id
//   result   | out_valid_o/out_stall_i | status, block_offset_kb, block_size_kb, merged
//   config   | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// Scans read, then evaluate, each entry. An allocate adds a calculate and a
// fill step per split, and a read and a write per entry shifted right; each
// merge adds a read and a write per entry shifted left, and immediate release
// rescans from entry zero after a merge. After reset, S_INIT writes the first
// entry before any transfer. A stalled result holds; the next item may be
// taken while it waits, and its result waits until the register frees.
module buddy_allocator_lazy_coalesce_core #(
  parameter int unsigned MaxBlocks  = balc_pkg::MaxBlocksDef,
  parameter int unsigned MinBlockKb = balc_pkg::MinBlockKbDef,
  parameter int unsigned OwnerBits  = balc_pkg::OwnerBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [13:0] request_kb_i,
  input  logic [15:0] owner_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [12:0] block_offset_kb_o,
  output logic [13:0] block_size_kb_o,
  output logic        merged_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [13:0] cfg_wdata_i
);
  import balc_pkg::*;

  dp_cmd_e  cmd;
  dp_stat_t stat;

  balc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  balc_dpath #(
    .MaxBlocks  (MaxBlocks),
    .MinBlockKb (MinBlockKb),
    .OwnerBits  (OwnerBits)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .operation_i       (operation_i),
    .request_kb_i      (request_kb_i),
    .owner_id_i        (owner_id_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .block_offset_kb_o (block_offset_kb_o),
    .block_size_kb_o   (block_size_kb_o),
    .merged_o          (merged_o)
  );

endmodule
